// File: hw/rtl/abbreviation_trigger_matcher_macros.svh
// Assertion macros for the trigger matcher checker.
`ifndef ABBREVIATION_TRIGGER_MATCHER_MACROS_SVH
`define ABBREVIATION_TRIGGER_MATCHER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ATM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define ATM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/atm_pkg.sv
// Shared types and constants of the trigger matcher.
package atm_pkg;

    localparam int MAX_TRIGGERS = 32;
    localparam int TRIG_CHARS   = 16;
    localparam int ENTRY_W      = $clog2(MAX_TRIGGERS);
    localparam int POS_W        = $clog2(TRIG_CHARS);
    localparam int COUNT_W      = POS_W + 1;
    localparam int SCAN_W       = ENTRY_W + 1;
    localparam int ACT_W        = 6;
    localparam int ROW_W        = TRIG_CHARS * 8;

    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_DELETE    = 8'h7F;
    localparam logic [7:0] CH_NONE      = 8'h00;

    localparam logic       CMD_KEY  = 1'b0;
    localparam logic       CMD_LOAD = 1'b1;

    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_FIRST  = 2'd1;
    localparam logic [1:0] EV_EXTEND = 2'd2;
    localparam logic [1:0] EV_FULL   = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic rd;
        logic cmp;
        logic finish;
        logic load_out;
    } ctl_cmd_t;

    typedef struct packed {
        logic is_append;
        logic scan_end;
        logic out_free;
    } ctl_status_t;

    typedef struct packed {
        logic               consume;
        logic               matched;
        logic [ENTRY_W-1:0] matched_index;
        logic [POS_W-1:0]   backspaces;
        logic [1:0]         match_event;
        logic               break_event;
    } result_t;

endpackage

// File: hw/rtl/atm_if.sv
// Channel interfaces: key/load items, results and configuration writes.
interface atm_in_if import atm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               cmd;
    logic               pressed;
    logic [7:0]         key_char;
    logic [ENTRY_W-1:0] entry;
    logic [POS_W-1:0]   position;
    modport source (output valid, cmd, pressed, key_char, entry, position, input ready);
    modport sink   (input valid, cmd, pressed, key_char, entry, position, output ready);
endinterface

interface atm_out_if import atm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               consume;
    logic               matched;
    logic [ENTRY_W-1:0] matched_index;
    logic [POS_W-1:0]   backspaces;
    logic [1:0]         match_event;
    logic               break_event;
    modport source (output valid, consume, matched, matched_index, backspaces,
                    match_event, break_event, input ready);
    modport sink   (input valid, consume, matched, matched_index, backspaces,
                    match_event, break_event, output ready);
endinterface

interface atm_cfg_if import atm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: hw/rtl/atm_ctrl.sv
// Controller: sequences accept, table walk, result build and output load.
module atm_ctrl import atm_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  ctl_status_t status,
    output ctl_cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = status.is_append ? ST_READ : ST_DONE;
                end
            end
            ST_READ:
            begin
                if (status.scan_end)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                cmd.cmp    = 1'b1;
                state_next = ST_READ;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/atm_datapath.sv
// Datapath: typed buffer, trigger row memory, row compare and output register.
module atm_datapath import atm_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_cmd,
    input  logic               in_pressed,
    input  logic [7:0]         in_key_char,
    input  logic [ENTRY_W-1:0] in_entry,
    input  logic [POS_W-1:0]   in_position,
    input  logic               cfg_valid,
    input  logic [ACT_W-1:0]   cfg_data,
    input  logic               out_ready,
    output logic               out_valid,
    output result_t            out_data,
    input  ctl_cmd_t           cmd,
    output ctl_status_t        status
);

    logic [ROW_W-1:0]   trig_mem [MAX_TRIGGERS];
    logic [ROW_W-1:0]   row_reg;
    logic [7:0]         typed_reg [TRIG_CHARS];
    logic [COUNT_W-1:0] count_reg;
    logic [7:0]         ch_reg;
    logic [SCAN_W-1:0]  scan_reg;
    logic               exact_reg, prefix_reg, starts_reg;
    logic [ENTRY_W-1:0] idx_reg;
    logic [ACT_W-1:0]   act_reg;
    result_t            res_reg;
    result_t            res_next;
    result_t            out_reg;
    logic               out_valid_reg;

    logic               is_bs, is_brk, is_full, is_key;
    logic [ACT_W-1:0]   live;
    logic [TRIG_CHARS-1:0] hit;
    logic [7:0]         term_byte;
    logic               head, term, row_exact, row_prefix, row_start;

    assign is_key  = (in_cmd == CMD_KEY) && in_pressed;
    assign is_bs   = (in_key_char == CH_BACKSPACE);
    assign is_brk  = (in_key_char == CH_NONE) || (in_key_char == CH_TAB) ||
                     (in_key_char == CH_NEWLINE) || (in_key_char == CH_DELETE);
    assign is_full = (count_reg >= COUNT_W'(TRIG_CHARS));
    assign live    = (act_reg > ACT_W'(MAX_TRIGGERS)) ? ACT_W'(MAX_TRIGGERS) : act_reg;

    assign status.is_append = is_key && !is_bs && !is_brk && !is_full;
    assign status.scan_end  = exact_reg || (ACT_W'(scan_reg) >= live);
    assign status.out_free  = !out_valid_reg || out_ready;

    // Row compare: typed chars are never zero, so a full head match also
    // guarantees the trigger is at least as long as the buffer.
    always_comb
    begin
        term_byte = '0;
        for (int j = 0; j < TRIG_CHARS; j++)
        begin
            hit[j] = (row_reg[j*8 +: 8] == typed_reg[j]) || (COUNT_W'(j) >= count_reg);
            if (POS_W'(j) == count_reg[POS_W-1:0])
            begin
                term_byte = row_reg[j*8 +: 8];
            end
        end
        head       = &hit;
        term       = (count_reg == COUNT_W'(TRIG_CHARS)) || (term_byte == CH_NONE);
        row_exact  = head && term;
        row_prefix = head && !term;
        row_start  = (row_reg[7:0] == ch_reg);
    end

    // Result for the accept cycle or for the end of the table walk
    always_comb
    begin
        res_next = '0;
        if (cmd.accept)
        begin
            res_next.break_event = is_key && !is_bs &&
                                   (is_full || (is_brk && count_reg != '0));
        end
        else if (exact_reg)
        begin
            res_next.consume       = 1'b1;
            res_next.matched       = 1'b1;
            res_next.matched_index = idx_reg;
            res_next.backspaces    = POS_W'(count_reg - 1'b1);
            res_next.match_event   = EV_FULL;
        end
        else if (prefix_reg)
        begin
            res_next.match_event = (count_reg == COUNT_W'(1)) ? EV_FIRST : EV_EXTEND;
        end
        else
        begin
            res_next.break_event = 1'b1;
            res_next.match_event = starts_reg ? EV_FIRST : EV_NONE;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            act_reg       <= '0;
            out_valid_reg <= 1'b0;
            scan_reg      <= '0;
            exact_reg     <= 1'b0;
            prefix_reg    <= 1'b0;
            starts_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                act_reg <= cfg_data;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.accept && is_key)
            begin
                scan_reg   <= '0;
                exact_reg  <= 1'b0;
                prefix_reg <= 1'b0;
                starts_reg <= 1'b0;
                if (is_bs)
                begin
                    if (count_reg != '0)
                    begin
                        count_reg <= count_reg - 1'b1;
                    end
                end
                else if (is_brk || is_full)
                begin
                    count_reg <= '0;
                end
                else
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.cmp)
            begin
                scan_reg   <= scan_reg + 1'b1;
                exact_reg  <= exact_reg | row_exact;
                prefix_reg <= prefix_reg | row_prefix;
                starts_reg <= starts_reg | row_start;
            end
            if (cmd.finish)
            begin
                if (exact_reg)
                begin
                    count_reg <= '0;
                end
                else if (!prefix_reg)
                begin
                    count_reg <= starts_reg ? COUNT_W'(1) : '0;
                end
            end
        end
    end

    // Payload: memory, buffer, results
    always_ff @(posedge clk)
    begin
        if (cmd.accept && in_cmd == CMD_LOAD)
        begin
            trig_mem[in_entry][{in_position, 3'b000} +: 8] <= in_key_char;
        end
        if (cmd.rd)
        begin
            row_reg <= trig_mem[scan_reg[ENTRY_W-1:0]];
        end
        if (cmd.cmp && row_exact && !exact_reg)
        begin
            idx_reg <= scan_reg[ENTRY_W-1:0];
        end
        if (cmd.accept || cmd.finish)
        begin
            res_reg <= res_next;
        end
        if (cmd.accept)
        begin
            ch_reg <= in_key_char;
            if (status.is_append)
            begin
                typed_reg[count_reg[POS_W-1:0]] <= in_key_char;
            end
        end
        if (cmd.finish && !exact_reg && !prefix_reg && starts_reg)
        begin
            typed_reg[0] <= ch_reg;
        end
        if (cmd.load_out)
        begin
            out_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// File: hw/rtl/abbreviation_trigger_matcher.sv
// Top level of the abbreviation trigger matcher.
// One item at a time. Load items, key releases, backspace, break keys and
// overflow skip the table walk. An appended key walks the trigger row
// memory one entry at a time (registered read, then compare of all 16
// positions), stopping at the first exact hit or after the last of at
// most 32 active entries. A result waits in an output register; the next
// key is taken once it is loaded.
// Configuration writes are accepted every cycle.
module abbreviation_trigger_matcher import atm_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    atm_in_if.sink    keys,
    atm_out_if.source results,
    atm_cfg_if.sink   cfg
);

    ctl_cmd_t    cmd;
    ctl_status_t status;
    result_t     out_data;

    assign cfg.ready = 1'b1;

    atm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (keys.valid),
        .in_ready (keys.ready),
        .status   (status),
        .cmd      (cmd)
    );

    atm_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_cmd      (keys.cmd),
        .in_pressed  (keys.pressed),
        .in_key_char (keys.key_char),
        .in_entry    (keys.entry),
        .in_position (keys.position),
        .cfg_valid   (cfg.valid),
        .cfg_data    (cfg.data),
        .out_ready   (results.ready),
        .out_valid   (results.valid),
        .out_data    (out_data),
        .cmd         (cmd),
        .status      (status)
    );

    assign results.consume       = out_data.consume;
    assign results.matched       = out_data.matched;
    assign results.matched_index = out_data.matched_index;
    assign results.backspaces    = out_data.backspaces;
    assign results.match_event   = out_data.match_event;
    assign results.break_event   = out_data.break_event;

endmodule

// File: hw/rtl/atm_checker.sv
// Port-level checker for the trigger matcher, bound to the top level.
`include "abbreviation_trigger_matcher_macros.svh"

module atm_checker import atm_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               consume,
    input logic               matched,
    input logic [ENTRY_W-1:0] matched_index,
    input logic [1:0]         match_event,
    input logic               break_event
);

    `ATM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `ATM_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(matched_index))
    `ATM_ASSERT_NOW(a_match_full, clk, rst_n, out_valid && matched, consume && match_event == EV_FULL && !break_event)
    `ATM_ASSERT_NEXT(a_one_at_time, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind abbreviation_trigger_matcher atm_checker u_atm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (keys.valid),
    .in_ready      (keys.ready),
    .out_valid     (results.valid),
    .out_ready     (results.ready),
    .consume       (results.consume),
    .matched       (results.matched),
    .matched_index (results.matched_index),
    .match_event   (results.match_event),
    .break_event   (results.break_event)
);

// File: tb/sv/tb_abbreviation_trigger_matcher.sv
// Self-checking testbench for the abbreviation trigger matcher.
module tb_abbreviation_trigger_matcher;
    import atm_pkg::*;

    typedef struct packed {
        logic               cmd;
        logic               pressed;
        logic [7:0]         key_char;
        logic [ENTRY_W-1:0] entry;
        logic [POS_W-1:0]   position;
    } key_item_t;

    logic clk;
    logic rst_n;

    atm_in_if  keys ();
    atm_out_if results ();
    atm_cfg_if cfg ();

    abbreviation_trigger_matcher u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .keys    (keys),
        .results (results),
        .cfg     (cfg)
    );

    // predictor state
    logic [7:0]       trig_mem [MAX_TRIGGERS*TRIG_CHARS];
    logic [7:0]       typed_buf [TRIG_CHARS];
    int unsigned      typed_len;
    logic [ACT_W-1:0] live_setting;

    // stimulus-side view of the loaded triggers
    logic [7:0]  plan_chars [MAX_TRIGGERS][TRIG_CHARS];
    int unsigned plan_len [MAX_TRIGGERS];

    key_item_t key_queue [$];
    result_t   result_queue [$];
    key_item_t cur_item;
    bit        beat_taken;
    int        gap_left;
    int        burst_left;
    int        stall_mode;
    int        stall_cnt;
    int        error_count;

    always #6 clk = ~clk;

    initial begin
        #40000000;
        $display("abbreviation_trigger_matcher regression: fail");
        $finish;
    end

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic int unsigned live_entries();
        return (live_setting > MAX_TRIGGERS) ? MAX_TRIGGERS : live_setting;
    endfunction

    function automatic int unsigned row_len(input int unsigned e);
        int unsigned n;
        n = 0;
        while (n < TRIG_CHARS && trig_mem[e*TRIG_CHARS+n] != CH_NONE)
            n++;
        return n;
    endfunction

    function automatic bit head_equal(input int unsigned e, input int unsigned len);
        for (int unsigned j = 0; j < len; j++)
            if (trig_mem[e*TRIG_CHARS+j] != typed_buf[j])
                return 0;
        return 1;
    endfunction

    function automatic result_t match_key(input key_item_t it);
        result_t     r;
        int unsigned tl;
        int unsigned hit;
        bit          exact;
        bit          prefix;
        bit          starts;
        r = '0;
        exact = 0;
        prefix = 0;
        hit = 0;
        if (it.cmd == CMD_LOAD) begin
            trig_mem[it.entry*TRIG_CHARS+it.position] = it.key_char;
        end else if (it.pressed) begin
            if (it.key_char == CH_BACKSPACE) begin
                if (typed_len > 0)
                    typed_len--;
            end else if (it.key_char == CH_NONE || it.key_char == CH_TAB ||
                         it.key_char == CH_NEWLINE || it.key_char == CH_DELETE) begin
                if (typed_len > 0) begin
                    r.break_event = 1'b1;
                    typed_len = 0;
                end
            end else if (typed_len >= TRIG_CHARS) begin
                r.break_event = 1'b1;
                typed_len = 0;
            end else begin
                typed_buf[typed_len] = it.key_char;
                typed_len++;
                for (int unsigned e = 0; e < live_entries() && !exact; e++) begin
                    tl = row_len(e);
                    if (tl == typed_len && head_equal(e, typed_len)) begin
                        exact = 1;
                        hit = e;
                    end else if (tl > typed_len && head_equal(e, typed_len)) begin
                        prefix = 1;
                    end
                end
                if (exact) begin
                    r.consume = 1'b1;
                    r.matched = 1'b1;
                    r.matched_index = hit[ENTRY_W-1:0];
                    r.backspaces = POS_W'(typed_len - 1);
                    r.match_event = EV_FULL;
                    typed_len = 0;
                end else if (prefix) begin
                    r.match_event = (typed_len == 1) ? EV_FIRST : EV_EXTEND;
                end else begin
                    r.break_event = 1'b1;
                    starts = 0;
                    for (int unsigned e = 0; e < live_entries(); e++)
                        if (trig_mem[e*TRIG_CHARS] == it.key_char)
                            starts = 1;
                    if (starts) begin
                        typed_buf[0] = it.key_char;
                        typed_len = 1;
                        r.match_event = EV_FIRST;
                    end else begin
                        typed_len = 0;
                    end
                end
            end
        end
        return r;
    endfunction

    // sender: bursts with random gaps, fields change on the falling edge
    always @(posedge clk) begin
        if (rst_n && keys.valid && keys.ready) begin
            result_queue.push_back(match_key(cur_item));
            beat_taken = 1;
        end
    end

    always @(negedge clk) begin
        if (rst_n && !(keys.valid && !beat_taken)) begin
            beat_taken = 0;
            if (gap_left > 0) begin
                gap_left--;
                keys.valid <= 1'b0;
            end else if (key_queue.size() > 0) begin
                cur_item = key_queue.pop_front();
                keys.valid    <= 1'b1;
                keys.cmd      <= cur_item.cmd;
                keys.pressed  <= cur_item.pressed;
                keys.key_char <= cur_item.key_char;
                keys.entry    <= cur_item.entry;
                keys.position <= cur_item.position;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 20);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                keys.valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern, switched every so often
    always @(negedge clk) begin
        if (rst_n) begin
            if (stall_cnt == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_cnt = $urandom_range(20, 300);
            end
            stall_cnt--;
            case (stall_mode)
                0: results.ready <= 1'b1;
                1: results.ready <= ($urandom_range(0, 9) < 7);
                2: results.ready <= (stall_cnt % 5 != 0);
                default: results.ready <= ($urandom_range(0, 9) < 2);
            endcase
        end
    end

    // monitor
    always @(posedge clk) begin
        result_t want;
        if (rst_n && results.valid && results.ready) begin
            if (result_queue.size() == 0) begin
                report("result beat with nothing expected");
            end else begin
                want = result_queue.pop_front();
                if (results.consume !== want.consume)
                    report($sformatf("consume %b want %b", results.consume, want.consume));
                if (results.matched !== want.matched)
                    report($sformatf("matched %b want %b", results.matched, want.matched));
                if (results.matched_index !== want.matched_index)
                    report($sformatf("matched_index %0d want %0d",
                                     results.matched_index, want.matched_index));
                if (results.backspaces !== want.backspaces)
                    report($sformatf("backspaces %0d want %0d",
                                     results.backspaces, want.backspaces));
                if (results.match_event !== want.match_event)
                    report($sformatf("match_event %0d want %0d",
                                     results.match_event, want.match_event));
                if (results.break_event !== want.break_event)
                    report($sformatf("break_event %b want %b",
                                     results.break_event, want.break_event));
            end
        end
    end

    function automatic key_item_t mk(input logic cmd, input logic pr, input logic [7:0] ch,
                                     input int e, input int p);
        key_item_t it;
        it.cmd = cmd;
        it.pressed = pr;
        it.key_char = ch;
        it.entry = ENTRY_W'(e);
        it.position = POS_W'(p);
        return it;
    endfunction

    task automatic push_key(input logic [7:0] ch);
        key_queue.push_back(mk(CMD_KEY, 1'b1, ch, $urandom, $urandom));
    endtask

    // writes a whole row, so the store stays defined
    task automatic load_trigger(input int e, input int len);
        logic [7:0] c;
        plan_len[e] = len;
        for (int p = 0; p < TRIG_CHARS; p++) begin
            c = (p < len) ? 8'(8'h61 + $urandom_range(0, 3)) : CH_NONE;
            if (p < len && $urandom_range(0, 15) == 0)
                c = 8'($urandom_range(8'h80, 8'hFF));
            plan_chars[e][p] = c;
            key_queue.push_back(mk(CMD_LOAD, $urandom, c, e, p));
        end
    endtask

    task automatic type_trigger(input int e);
        int n;
        n = plan_len[e];
        if ($urandom_range(0, 4) == 0 && n > 1)
            n = $urandom_range(1, n - 1);
        for (int p = 0; p < n; p++) begin
            if ($urandom_range(0, 19) == 0)
                push_key(CH_BACKSPACE);
            push_key(plan_chars[e][p]);
        end
    endtask

    task automatic random_key(input int act);
        int r;
        r = $urandom_range(0, 99);
        if (r < 55 && act > 0)
            type_trigger($urandom_range(0, act - 1));
        else if (r < 70)
            push_key(8'(8'h61 + $urandom_range(0, 4)));
        else if (r < 76)
            push_key(CH_BACKSPACE);
        else if (r < 82)
            case ($urandom_range(0, 3))
                0: push_key(CH_NONE);
                1: push_key(CH_TAB);
                2: push_key(CH_NEWLINE);
                default: push_key(CH_DELETE);
            endcase
        else if (r < 90)
            key_queue.push_back(mk(CMD_KEY, 1'b0, $urandom, $urandom, $urandom));
        else if (r < 97)
            push_key($urandom);
        else
            load_trigger($urandom_range(0, MAX_TRIGGERS - 1), $urandom_range(1, 16));
    endtask

    task automatic wait_drained();
        while (key_queue.size() > 0 || keys.valid || result_queue.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_active(input int val);
        @(negedge clk);
        cfg.valid = 1'b1;
        cfg.data = ACT_W'(val);
        do @(posedge clk); while (!cfg.ready);
        live_setting = ACT_W'(val);
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    initial begin
        int act_set [7];
        int act;
        clk = 0;
        rst_n = 0;
        keys.valid = 0;
        keys.cmd = 0;
        keys.pressed = 0;
        keys.key_char = 0;
        keys.entry = 0;
        keys.position = 0;
        results.ready = 0;
        cfg.valid = 0;
        cfg.data = 0;
        typed_len = 0;
        live_setting = 0;
        beat_taken = 0;
        gap_left = 0;
        burst_left = 1;
        stall_cnt = 0;
        error_count = 0;
        repeat (11) @(negedge clk);
        rst_n = 1;

        // fill every row before any entry becomes active
        for (int e = 0; e < MAX_TRIGGERS; e++)
            load_trigger(e, (e % 8 == 7) ? 16 : $urandom_range(1, 5));
        wait_drained();
        write_active(32);

        // directed: trigger 0 made "ab", entry 1 "b"
        for (int p = 0; p < 3; p++)
            key_queue.push_back(mk(CMD_LOAD, 1'b0, (p == 0) ? 8'h61 : (p == 1) ? 8'h62 : 8'h00,
                                   0, p));
        key_queue.push_back(mk(CMD_LOAD, 1'b1, 8'h62, 1, 0));
        key_queue.push_back(mk(CMD_LOAD, 1'b1, 8'h00, 1, 1));
        plan_chars[0][0] = 8'h61; plan_chars[0][1] = 8'h62; plan_len[0] = 2;
        plan_chars[1][0] = 8'h62; plan_len[1] = 1;
        key_queue.push_back(mk(CMD_KEY, 1'b0, 8'hFF, 31, 15));
        push_key(CH_BACKSPACE);
        push_key(CH_TAB);
        push_key(8'h61);
        push_key(8'h62);
        push_key(8'h61);
        push_key(CH_NEWLINE);
        push_key(8'h61);
        push_key(CH_BACKSPACE);
        push_key(8'h61);
        push_key(CH_DELETE);
        push_key(8'h61);
        push_key(CH_NONE);
        push_key(8'h61);
        push_key(8'hFF);
        push_key(8'h61);
        push_key(8'h61);
        push_key(8'h62);
        type_trigger(7);
        type_trigger(31);
        wait_drained();

        act_set = '{0, 63, 1, 32, 0, 32, 63};
        act_set[4] = $urandom_range(2, 31);
        act_set[5] = $urandom_range(33, 62);
        for (int ph = 0; ph < 7; ph++) begin
            write_active(act_set[ph]);
            act = (act_set[ph] > MAX_TRIGGERS) ? MAX_TRIGGERS : act_set[ph];
            while (key_queue.size() < 200)
                random_key(act);
            wait_drained();
        end

        if (error_count == 0)
            $display("abbreviation_trigger_matcher regression: pass");
        else
            $display("abbreviation_trigger_matcher regression: fail");
        $finish;
    end

endmodule
